// File: design/assert_macros.svh
// Assertion macros shared by the order hash ledger RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk_s, rst_s, prop, msg)
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg)
`endif
`endif

// File: design/ohl_pkg.sv
// Package for the order hash ledger: sizes, command codes, item types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ohl_pkg;
  localparam int SLOTS     = 1024;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int HASH_BITS = $clog2(SLOTS + 1) - 1;
  localparam int CNT_W     = 10;
  localparam int ADDR_W    = 3;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(716);
  localparam logic [63:0] GOLDEN = 64'h9E37_79B9_7F4A_7C15;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_TAKE   = 3'd1;
  localparam logic [2:0] CMD_RETIRE = 3'd2;
  localparam logic [2:0] CMD_FIND   = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  typedef struct packed {
    logic [2:0]         command;
    logic [63:0]        order_id;
    logic               side;
    logic signed [31:0] price;
    logic [30:0]        lots;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic               side_res;
    logic signed [31:0] price_res;
    logic [30:0]        taken;
    logic [30:0]        remaining;
    logic [CNT_W-1:0]   occupancy;
  } out_item_t;

  typedef struct packed {
    logic [63:0]        order_id;
    logic               side;
    logic signed [31:0] price;
    logic [30:0]        lots;
  } entry_t;

  typedef struct packed {
    in_item_t          item;
    logic [SLOT_W-1:0] home;
    logic              reject;
  } job_t;

  typedef struct packed {
    logic init_busy;
  } ctl_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] a);
    return (a == SLOT_W'(SLOTS - 1)) ? '0 : a + 1'b1;
  endfunction
endpackage
`default_nettype wire

// File: design/ohl_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ohl_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/ohl_hash.sv
// Iterative Fibonacci hash: one 32x32 partial product per cycle, three steps.
// Depends on ohl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ohl_hash import ohl_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [63:0]       id,
  output logic                   done,
  output logic [SLOT_W-1:0]      home
);
  logic [1:0]  step_r, step_nxt;
  logic [63:0] id_r, id_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        done_r;
  logic [31:0] op_a, op_b;
  logic [63:0] prod;

  always_comb begin
    op_a = id_r[31:0];
    op_b = GOLDEN[31:0];
    case (step_r)
      2'd2:    op_a = id_r[63:32];
      2'd3:    op_b = GOLDEN[63:32];
      default: ;
    endcase
    prod = 64'(op_a) * 64'(op_b);
    step_nxt = step_r;
    id_nxt   = id_r;
    acc_nxt  = acc_r;
    if (start) begin
      step_nxt = 2'd1;
      id_nxt   = id;
    end else if (step_r == 2'd1) begin
      acc_nxt  = prod;
      step_nxt = 2'd2;
    end else if (step_r != 2'd0) begin
      acc_nxt  = {acc_r[63:32] + prod[31:0], acc_r[31:0]};
      step_nxt = (step_r == 2'd3) ? 2'd0 : 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 2'd0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= (step_r == 2'd3) && !start;
    end
    id_r  <= id_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign home = SLOT_W'(acc_r[63 -: HASH_BITS]);
endmodule
`default_nettype wire

// File: design/ohl_queue.sv
// Short job queue between the front and the back.
// Depends on ohl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ohl_queue import ohl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      full,
  output logic      empty
);
  job_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
    if (push) begin
      q_r[wp_r] <= push_job;
    end
  end

  assign head  = q_r[rp_r];
  assign full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
endmodule
`default_nettype wire

// File: design/ohl_front.sv
// Front end: takes items, screens them and hashes the id to its home slot.
// Depends on ohl_pkg and ohl_hash.
`timescale 1ns / 1ps
`default_nettype none
module ohl_front import ohl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  in_item_t  in_item,
  output logic      busy,
  input  ctl_t      ctl,
  output logic      push,
  output job_t      push_job,
  input  wire logic q_full
);
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_HASH = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0] st_r, st_nxt;
  job_t       job_r, job_nxt;
  logic       acc, lookup, bad, hstart, hdone;
  logic [SLOT_W-1:0] hhome;

  ohl_hash u_hash (
    .clk(clk), .rst_n(rst_n), .start(hstart), .id(in_item.order_id),
    .done(hdone), .home(hhome)
  );

  always_comb begin
    acc    = start && !busy;
    lookup = (in_item.command inside {CMD_INSERT, CMD_TAKE, CMD_RETIRE, CMD_FIND});
    bad    = (in_item.command > CMD_CLEAR) ||
             (lookup && in_item.order_id == 64'd0) ||
             ((in_item.command inside {CMD_INSERT, CMD_TAKE}) && in_item.lots == 31'd0);
    hstart  = 1'b0;
    st_nxt  = st_r;
    job_nxt = job_r;
    push    = 1'b0;
    case (st_r)
      F_IDLE: begin
        if (acc) begin
          job_nxt.item   = in_item;
          job_nxt.home   = '0;
          job_nxt.reject = bad;
          hstart = !bad && lookup;
          st_nxt = hstart ? F_HASH : F_PUSH;
        end
      end
      F_HASH: begin
        if (hdone) begin
          job_nxt.home = hhome;
          st_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          push   = 1'b1;
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    job_r <= job_nxt;
  end

  assign busy     = (st_r != F_IDLE) || ctl.init_busy;
  assign push_job = job_r;
endmodule
`default_nettype wire

// File: design/ohl_back.sv
// Back end: probes the slot store, applies commands, backward-shift erasure.
// Depends on ohl_pkg, ohl_ram and ohl_hash.
`timescale 1ns / 1ps
`default_nettype none
module ohl_back import ohl_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  job_t                  q_head,
  output logic                  q_pop,
  input  wire logic [CNT_W-1:0] limit,
  output ctl_t                  ctl,
  output logic                  out_valid,
  output out_item_t             out_item
);
  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;
  localparam logic [3:0] S_REJ  = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_RST  = 4'd6;
  localparam logic [3:0] S_RRD  = 4'd7;
  localparam logic [3:0] S_RCHK = 4'd8;
  localparam logic [3:0] S_HASH = 4'd9;
  localparam logic [3:0] S_MOVE = 4'd10;

  logic [3:0]        st_r, st_nxt;
  logic [SLOT_W-1:0] at_r, at_nxt, hole_r, hole_nxt;
  logic [SLOT_W:0]   n_r, n_nxt;
  job_t              job_r, job_nxt;
  entry_t            ent_r, ent_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              r_side_r, r_side_nxt;
  logic signed [31:0] r_price_r, r_price_nxt;
  logic [30:0]       r_tk_r, r_tk_nxt, r_rem_r, r_rem_nxt;
  logic              out_valid_r;
  out_item_t         out_r;

  logic              we;
  logic [SLOT_W-1:0] waddr;
  entry_t            wdata, rdata;
  logic              hstart, hdone, stays;
  logic [SLOT_W-1:0] ideal;
  logic              fin, f_st, f_side;
  logic signed [31:0] f_price;
  logic [30:0]       f_tk, f_rem, tk, rem;

  ohl_ram #(.W($bits(entry_t)), .D(SLOTS)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(at_r), .rdata(rdata)
  );

  ohl_hash u_hash (
    .clk(clk), .rst_n(rst_n), .start(hstart), .id(rdata.order_id),
    .done(hdone), .home(ideal)
  );

  always_comb begin
    st_nxt = st_r;  at_nxt = at_r;  hole_nxt = hole_r;  n_nxt = n_r;
    job_nxt = job_r;  ent_nxt = ent_r;  cnt_nxt = cnt_r;
    r_side_nxt = r_side_r;  r_price_nxt = r_price_r;
    r_tk_nxt = r_tk_r;  r_rem_nxt = r_rem_r;
    we = 1'b0;  waddr = at_r;  wdata = '0;
    hstart = 1'b0;  q_pop = 1'b0;
    fin = 1'b0;  f_st = 1'b1;  f_side = 1'b0;  f_price = '0;  f_tk = '0;  f_rem = '0;
    tk  = (job_r.item.lots < rdata.lots) ? job_r.item.lots : rdata.lots;
    rem = rdata.lots - tk;
    stays = (hole_r <= at_r) ? (hole_r < ideal && ideal <= at_r)
                             : (hole_r < ideal || ideal <= at_r);
    case (st_r)
      S_INIT, S_CLR: begin
        we = 1'b1;
        if (at_r == SLOT_W'(SLOTS - 1)) begin
          cnt_nxt = '0;
          fin  = (st_r == S_CLR);
          f_st = 1'b0;
          st_nxt = S_IDLE;
        end else begin
          at_nxt = at_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          job_nxt = q_head;
          at_nxt  = q_head.home;
          n_nxt   = '0;
          if (q_head.item.command == CMD_CLEAR) begin
            at_nxt = '0;
            st_nxt = S_CLR;
          end else if (q_head.reject ||
                       (q_head.item.command == CMD_INSERT && cnt_r >= limit)) begin
            st_nxt = S_REJ;
          end else begin
            st_nxt = S_RD;
          end
        end
      end
      S_REJ: begin
        fin = 1'b1;
        st_nxt = S_IDLE;
      end
      S_RD: st_nxt = S_CHK;
      S_CHK: begin
        if (rdata.order_id == 64'd0) begin
          fin = 1'b1;
          st_nxt = S_IDLE;
          if (job_r.item.command == CMD_INSERT) begin
            we = 1'b1;
            wdata = '{order_id: job_r.item.order_id, side: job_r.item.side,
                      price: job_r.item.price, lots: job_r.item.lots};
            cnt_nxt = cnt_r + 1'b1;
            f_st = 1'b0;  f_side = job_r.item.side;
            f_price = job_r.item.price;  f_rem = job_r.item.lots;
          end
        end else if (rdata.order_id == job_r.item.order_id) begin
          r_side_nxt = rdata.side;
          r_price_nxt = rdata.price;
          hole_nxt = at_r;
          case (job_r.item.command)
            CMD_FIND: begin
              fin = 1'b1;  st_nxt = S_IDLE;
              f_st = 1'b0;  f_side = rdata.side;  f_price = rdata.price;
              f_rem = rdata.lots;
            end
            CMD_TAKE: begin
              r_tk_nxt = tk;  r_rem_nxt = rem;
              if (rem != 31'd0) begin
                we = 1'b1;
                wdata = rdata;
                wdata.lots = rem;
                fin = 1'b1;  st_nxt = S_IDLE;
                f_st = 1'b0;  f_side = rdata.side;  f_price = rdata.price;
                f_tk = tk;  f_rem = rem;
              end else begin
                st_nxt = S_RST;
              end
            end
            CMD_RETIRE: begin
              r_tk_nxt = rdata.lots;  r_rem_nxt = '0;
              st_nxt = S_RST;
            end
            default: begin
              fin = 1'b1;  st_nxt = S_IDLE;
            end
          endcase
        end else if (n_r == (SLOT_W+1)'(SLOTS - 1)) begin
          fin = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          n_nxt = n_r + 1'b1;
          at_nxt = next_slot(at_r);
          st_nxt = S_RD;
        end
      end
      S_RST: begin
        we = 1'b1;
        waddr = hole_r;
        at_nxt = next_slot(hole_r);
        st_nxt = S_RRD;
      end
      S_RRD: st_nxt = S_RCHK;
      S_RCHK: begin
        if (rdata.order_id == 64'd0) begin
          if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
          fin = 1'b1;  st_nxt = S_IDLE;
          f_st = 1'b0;  f_side = r_side_r;  f_price = r_price_r;
          f_tk = r_tk_r;  f_rem = r_rem_r;
        end else begin
          ent_nxt = rdata;
          hstart = 1'b1;
          st_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (hdone) begin
          if (stays) begin
            at_nxt = next_slot(at_r);
            st_nxt = S_RRD;
          end else begin
            st_nxt = S_MOVE;
          end
        end
      end
      S_MOVE: begin
        we = 1'b1;
        waddr = hole_r;
        wdata = ent_r;
        hole_nxt = at_r;
        st_nxt = S_RST;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_INIT;
      at_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      at_r        <= at_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= fin;
    end
    hole_r    <= hole_nxt;
    n_r       <= n_nxt;
    job_r     <= job_nxt;
    ent_r     <= ent_nxt;
    r_side_r  <= r_side_nxt;
    r_price_r <= r_price_nxt;
    r_tk_r    <= r_tk_nxt;
    r_rem_r   <= r_rem_nxt;
    if (fin) begin
      out_r <= '{status: f_st, side_res: f_side, price_res: f_price,
                 taken: f_tk, remaining: f_rem, occupancy: cnt_nxt};
    end
  end

  assign ctl.init_busy = (st_r == S_INIT);
  assign out_valid     = out_valid_r;
  assign out_item      = out_r;
endmodule
`default_nettype wire

// File: design/order_hash_ledger.sv
// Order hash ledger: the front takes each item through accept, id hash and push;
// the back reads and checks one slot per probe step; screened-out items skip the hash
// and are answered by the back without a probe. Erasure reads, checks and rehashes each
// following slot and moves an entry that does not stay into the hole; clear all writes
// every slot in turn. Items are carried out one at a time; the result cannot be stalled.
// After reset a clearing pass over all slots holds busy high.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module order_hash_ledger import ohl_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  in_item_t               in_item,
  output logic                   out_valid,
  output out_item_t              out_item,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  logic [CNT_W-1:0] limit_r;
  ctl_t ctl;
  logic push, pop, q_full, q_empty;
  job_t push_job, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (psel && penable && pwrite && paddr[ADDR_W-1:2] == '0) begin
      limit_r <= pwdata[CNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == '0) ? 32'(limit_r) : 32'd0;

  ohl_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item), .busy(busy),
    .ctl(ctl), .push(push), .push_job(push_job), .q_full(q_full)
  );

  ohl_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_job(push_job), .pop(pop),
    .head(head), .full(q_full), .empty(q_empty)
  );

  ohl_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_head(head), .q_pop(pop),
    .limit(limit_r), .ctl(ctl), .out_valid(out_valid), .out_item(out_item)
  );

  `ASSERT_CLK(a_gap, clk, rst_n, out_valid |=> !out_valid, "back-to-back results")
  `ASSERT_CLK(a_take, clk, rst_n, (start && !busy) |=> busy, "front idle after accept")
  `ASSERT_NEVER(a_ovf, clk, rst_n, push && q_full, "queue overflow")
  `ASSERT_NEVER(a_unf, clk, rst_n, pop && q_empty, "queue underflow")
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking bench for order_hash_ledger: random and directed commands, an APB limit
// register, and a shadow probe table predicting every result. Depends on ohl_pkg.
`timescale 1ns / 1ps
module tb_top;
  import ohl_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_item_t          in_item = '0;
  logic              out_valid;
  out_item_t         out_item;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  localparam logic [ADDR_W-1:0] REG_ORDER_LIMIT = ADDR_W'(0);
  localparam int STALL_LIMIT = 20000;

  order_hash_ledger u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow ledger
  bit          slot_used[SLOTS];
  entry_t      slot_ent[SLOTS];
  int unsigned held;
  logic [9:0]  held_limit = LIMIT_RST;

  out_item_t   pending_res[$];
  logic [63:0] id_pool[$];
  int          n_errors = 0;
  int          idle_cycles = 0;
  bit          no_gaps = 1'b0;

  function automatic int home_slot(logic [63:0] id);
    logic [63:0] h;
    h = id * GOLDEN;
    return int'(h[63 -: HASH_BITS]);
  endfunction

  function automatic int wrap_next(int a);
    return (a + 1 >= SLOTS) ? 0 : a + 1;
  endfunction

  function automatic bit lookup_slot(logic [63:0] id, output int at);
    int p;
    p = home_slot(id);
    at = 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (!slot_used[p]) return 1'b0;
      if (slot_ent[p].order_id == id) begin
        at = p;
        return 1'b1;
      end
      p = wrap_next(p);
    end
    return 1'b0;
  endfunction

  function automatic void erase_slot(int hole);
    int  probe;
    int  ideal;
    bit  stays;
    forever begin
      probe = hole;
      slot_used[hole] = 1'b0;
      slot_ent[hole] = '0;
      forever begin
        probe = wrap_next(probe);
        if (!slot_used[probe]) begin
          if (held > 0) held--;
          return;
        end
        ideal = home_slot(slot_ent[probe].order_id);
        stays = (hole <= probe) ? (hole < ideal && ideal <= probe)
                                : (hole < ideal || ideal <= probe);
        if (!stays) break;
      end
      slot_used[hole] = 1'b1;
      slot_ent[hole] = slot_ent[probe];
      hole = probe;
    end
  endfunction

  function automatic out_item_t ledger_apply(in_item_t x);
    out_item_t r;
    int        at;
    entry_t    e;
    r = '0;
    r.status = 1'b1;
    case (x.command)
      CMD_INSERT: begin
        if (x.order_id != 0 && x.lots != 0 && held < held_limit) begin
          at = home_slot(x.order_id);
          for (int n = 0; n < SLOTS; n++) begin
            if (!slot_used[at]) begin
              slot_used[at] = 1'b1;
              slot_ent[at] = '{x.order_id, x.side, x.price, x.lots};
              held++;
              r.status = 1'b0;
              r.side_res = x.side;
              r.price_res = x.price;
              r.remaining = x.lots;
              break;
            end
            if (slot_ent[at].order_id == x.order_id) break;
            at = wrap_next(at);
          end
        end
      end
      CMD_TAKE: begin
        if (x.order_id != 0 && x.lots != 0 && lookup_slot(x.order_id, at)) begin
          e = slot_ent[at];
          r.taken = (x.lots < e.lots) ? x.lots : e.lots;
          r.remaining = e.lots - r.taken;
          if (r.remaining == 0) erase_slot(at);
          else slot_ent[at].lots = r.remaining;
          r.status = 1'b0;
          r.side_res = e.side;
          r.price_res = e.price;
        end
      end
      CMD_RETIRE: begin
        if (x.order_id != 0 && lookup_slot(x.order_id, at)) begin
          e = slot_ent[at];
          erase_slot(at);
          r.status = 1'b0;
          r.side_res = e.side;
          r.price_res = e.price;
          r.taken = e.lots;
        end
      end
      CMD_FIND: begin
        if (x.order_id != 0 && lookup_slot(x.order_id, at)) begin
          r.status = 1'b0;
          r.side_res = slot_ent[at].side;
          r.price_res = slot_ent[at].price;
          r.remaining = slot_ent[at].lots;
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          slot_used[i] = 1'b0;
          slot_ent[i] = '0;
        end
        held = 0;
        r.status = 1'b0;
      end
      default: ;
    endcase
    r.occupancy = held[CNT_W-1:0];
    return r;
  endfunction

  task automatic send_item(in_item_t x);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= x;
    do @(posedge clk); while (busy);
    pending_res.push_back(ledger_apply(x));
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_limit(logic [9:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_ORDER_LIMIT;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    held_limit = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic in_item_t mk(logic [2:0] c, logic [63:0] id, logic s,
                                  logic [31:0] p, logic [30:0] l);
    in_item_t x;
    x.command = c;
    x.order_id = id;
    x.side = s;
    x.price = p;
    x.lots = l;
    return x;
  endfunction

  function automatic logic [63:0] crowded_id();
    logic [63:0] id;
    do id = {$urandom, $urandom}; while (home_slot(id) < SLOTS - 8 || id == 0);
    return id;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_item);
        n_errors++;
      end else begin
        out_item_t e;
        e = pending_res.pop_front();
        if (e.status !== out_item.status)
          $display("%0t: status exp %0d got %0d", $time, e.status, out_item.status);
        if (e.side_res !== out_item.side_res)
          $display("%0t: side_res exp %0d got %0d", $time, e.side_res, out_item.side_res);
        if (e.price_res !== out_item.price_res)
          $display("%0t: price_res exp %0d got %0d", $time, e.price_res, out_item.price_res);
        if (e.taken !== out_item.taken)
          $display("%0t: taken exp %0d got %0d", $time, e.taken, out_item.taken);
        if (e.remaining !== out_item.remaining)
          $display("%0t: remaining exp %0d got %0d", $time, e.remaining, out_item.remaining);
        if (e.occupancy !== out_item.occupancy)
          $display("%0t: occupancy exp %0d got %0d", $time, e.occupancy, out_item.occupancy);
        if (e !== out_item) n_errors++;
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_directed;
    logic [63:0] a;
    logic [63:0] b;
    a = crowded_id();
    b = crowded_id();
    send_item(mk(CMD_INSERT, '1, 1'b1, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_item(mk(CMD_INSERT, 64'd1, 1'b0, 32'h8000_0000, 31'd1));
    send_item(mk(CMD_INSERT, 64'd0, 1'b0, 32'd5, 31'd5));
    send_item(mk(CMD_INSERT, a, 1'b1, 32'd7, 31'd0));
    send_item(mk(CMD_INSERT, a, 1'b1, 32'd7, 31'd10));
    send_item(mk(CMD_INSERT, a, 1'b0, 32'd9, 31'd3));
    send_item(mk(CMD_INSERT, b, 1'b0, 32'hFFFF_FFFF, 31'd4));
    send_item(mk(CMD_FIND, '1, 1'b0, '0, '0));
    send_item(mk(CMD_FIND, 64'd0, 1'b0, '0, '0));
    send_item(mk(CMD_TAKE, a, 1'b0, '0, 31'd3));
    send_item(mk(CMD_TAKE, a, 1'b0, '0, 31'd0));
    send_item(mk(CMD_TAKE, a, 1'b0, '0, 31'h7FFF_FFFF));
    send_item(mk(CMD_FIND, b, 1'b0, '0, '0));
    send_item(mk(CMD_RETIRE, '1, 1'b0, '0, '0));
    send_item(mk(CMD_RETIRE, '1, 1'b0, '0, '0));
    send_item(mk(CMD_TAKE, 64'd12345, 1'b0, '0, 31'd1));
    send_item(mk(3'd5, 64'd1, 1'b1, '1, '1));
    send_item(mk(3'd6, 64'd1, 1'b0, '0, 31'd1));
    send_item(mk(3'd7, b, 1'b1, '1, '1));
    send_item(mk(CMD_CLEAR, '0, 1'b0, '0, '0));
    send_item(mk(CMD_FIND, b, 1'b0, '0, '0));
  endtask

  task automatic test_limit;
    write_limit(10'd0);
    send_item(mk(CMD_INSERT, 64'd77, 1'b1, 32'd1, 31'd1));
    write_limit(10'd3);
    for (int i = 0; i < 4; i++) send_item(mk(CMD_INSERT, crowded_id(), 1'b0, $urandom, 31'd2));
    send_item(mk(CMD_CLEAR, '0, 1'b0, '0, '0));
    write_limit(10'd1023);
    write_limit(LIMIT_RST);
  endtask

  task automatic test_random(int count);
    in_item_t x;
    int       r;
    for (int i = 0; i < 48; i++)
      id_pool.push_back((i % 3 == 0) ? {$urandom, $urandom} | 64'd1 : crowded_id());
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (i == count / 2) drain();
      if (i == count / 3) write_limit(10'd20);
      if (i == 2 * count / 3) write_limit(LIMIT_RST);
      r = $urandom_range(0, 99);
      x = mk(CMD_FIND, id_pool[$urandom_range(0, id_pool.size() - 1)], $urandom_range(0, 1),
             $urandom, 31'($urandom_range(1, 8)));
      if ($urandom_range(0, 9) == 0) x.lots = 31'($urandom);
      if (r < 40) x.command = CMD_INSERT;
      else if (r < 62) x.command = CMD_TAKE;
      else if (r < 74) x.command = CMD_RETIRE;
      else if (r < 86) x.command = CMD_FIND;
      else if (r < 90) x.command = 3'($urandom_range(5, 7));
      else if (r < 93) x.order_id = '0;
      else if (r < 95) x.lots = '0;
      else if (r < 99) x.order_id = {$urandom, $urandom};
      else x.command = CMD_CLEAR;
      if (r >= 90 && r < 95) x.command = 3'($urandom_range(0, 3));
      send_item(x);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_limit(LIMIT_RST);
    test_directed();
    test_limit();
    test_random(620);
    drain();
    repeat (50) @(posedge clk);
    if (n_errors == 0 && pending_res.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+design
design/ohl_pkg.sv
design/ohl_ram.sv
design/ohl_hash.sv
design/ohl_queue.sv
design/ohl_front.sv
design/ohl_back.sv
design/order_hash_ledger.sv
tb/sv/tb_top.sv
